// ----- hw/rtl/smpq_pkg.sv -----
package smpq_pkg;

    localparam int VALUE_W = 32;
    localparam int OCC_W   = 5;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic                       operation;
        logic signed [VALUE_W-1:0]  value_in;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  value_out;
        status_t                    status;
        logic [OCC_W-1:0]           occupancy;
    } out_item_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic                       enq;
        logic                       deq;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/smpq_cell.sv -----
module smpq_cell
    import smpq_pkg::*;
(
    input  logic                       clk,
    input  cell_ctrl_t                 ctrl,
    input  logic                       occupied,
    input  logic                       left_shift,
    input  logic signed [VALUE_W-1:0]  left_value,
    input  logic signed [VALUE_W-1:0]  right_value,
    output logic                       shift,
    output logic signed [VALUE_W-1:0]  value
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // new value sorts before this entry, so this entry moves one cell up
    assign shift = occupied && (ctrl.value < value_reg);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.enq)
        begin
            if (left_shift)
                value_next = left_value;
            else if (shift || !occupied)
                value_next = ctrl.value;
        end
        else if (ctrl.deq)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- hw/rtl/sorted_min_priority_queue.sv -----
// sorted minimum priority queue built as a row of compare-and-shift cells
// result item is registered and valid in the cycle after the input item is accepted
// throughput: one item per cycle, as every cell compares and shifts
//   together; input stalls only while a result waits on out_ready
// reset: entry count and output valid clear at once; entry values are
//   undefined until written and are never read beyond the count
module sorted_min_priority_queue
    import smpq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    // count must hold CAPACITY itself
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    out_item_t     out_data_reg;
    out_item_t     out_data_next;

    logic          accept;
    logic          is_enq;
    logic          full;
    logic          empty;
    cell_ctrl_t    ctrl;

    // per-cell taps, each read at a fixed place
    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic                      cell_shift [CAPACITY];
    logic                      cell_occ   [CAPACITY];

    // output register decouples the two sides, accept while it drains
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign is_enq = (in_data.operation == OP_ENQUEUE);
    assign full   = (count_reg == CW'(CAPACITY));
    assign empty  = (count_reg == '0);

    // dropped enqueues and empty dequeues leave the row untouched
    assign ctrl.enq   = accept && is_enq && !full;
    assign ctrl.deq   = accept && !is_enq && !empty;
    assign ctrl.value = in_data.value_in;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                      left_shift;
            logic signed [VALUE_W-1:0] left_value;
            logic signed [VALUE_W-1:0] right_value;

            assign cell_occ[gi] = (CW'(gi) < count_reg);

            if (gi == 0)
            begin : g_first
                // nothing shifts into the head cell
                assign left_shift = 1'b0;
                assign left_value = '0;
            end
            else
            begin : g_mid
                assign left_shift = cell_shift[gi-1];
                assign left_value = cell_value[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                // tail cell drops out of the count on a dequeue
                assign right_value = '0;
            end
            else
            begin : g_inner
                assign right_value = cell_value[gi+1];
            end

            smpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (cell_occ[gi]),
                .left_shift  (left_shift),
                .left_value  (left_value),
                .right_value (right_value),
                .shift       (cell_shift[gi]),
                .value       (cell_value[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next              = count_reg;
        out_data_next.value_out = '0;
        out_data_next.status    = STATUS_OK;
        if (is_enq)
        begin
            if (full)
                out_data_next.status = STATUS_FULL;
            else
                count_next = count_reg + 1'b1;
        end
        else
        begin
            if (empty)
            begin
                out_data_next.status = STATUS_EMPTY;
            end
            else
            begin
                // head cell always holds the smallest value
                out_data_next.value_out = cell_value[0];
                count_next = count_reg - 1'b1;
            end
        end
        // occupancy carries only the low bits of the count
        out_data_next.occupancy = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2)) |-> (cell_value[0] <= cell_value[1]))
        else $error("head cells out of order");

    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.deq |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("dequeue did not decrement count");

    a_deq_value: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.deq |=> (out_data.value_out == $past(cell_value[0])))
        else $error("dequeue result is not the head value");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_enq && full) |=>
            ($stable(count_reg) && out_data.status == STATUS_FULL))
        else $error("enqueue while full changed the queue");
`endif

endmodule

// ----- verif/sorted_min_priority_queue_tb.sv -----
module sorted_min_priority_queue_tb;
    import smpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int QUIET_TAIL    = 200;
    localparam int MAX_IDLE      = 18;
    localparam int REPORT_LIMIT  = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic signed [VALUE_W-1:0] MAX_VALUE = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] MIN_VALUE = 32'sh8000_0000;

    // one item waiting to go out, with the idle burst that follows it
    typedef struct {
        in_item_t item;
        int       gap;
        bit       drain_first;
    } queued_item_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    queued_item_t pending_items[$];
    out_item_t    awaited_results[$];

    // shadow copy of the sorted store and its fill level
    logic signed [VALUE_W-1:0] shadow_values [QUEUE_DEPTH];
    int shadow_count = 0;

    int mismatches   = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int send_idle    = 0;
    int recv_idle    = 0;

    sorted_min_priority_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // apply one accepted item to the shadow store and return its result
    function automatic out_item_t predict_queue_op(in_item_t it);
        out_item_t r;
        logic signed [VALUE_W-1:0] v;
        int pos;
        int i;
        r.value_out = '0;
        r.status    = STATUS_OK;
        v           = it.value_in;
        if (it.operation == OP_ENQUEUE)
        begin
            if (shadow_count >= QUEUE_DEPTH)
                r.status = STATUS_FULL;
            else
            begin
                // new value goes after every entry less than or equal to it
                pos = 0;
                while (pos < shadow_count && !(v < shadow_values[pos]))
                    pos++;
                for (i = shadow_count; i > pos; i--)
                    shadow_values[i] = shadow_values[i-1];
                shadow_values[pos] = v;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                r.status = STATUS_EMPTY;
            else
            begin
                r.value_out = shadow_values[0];
                for (i = 1; i < shadow_count; i++)
                    shadow_values[i-1] = shadow_values[i];
                shadow_count--;
            end
        end
        r.occupancy = OCC_W'(shadow_count);
        return r;
    endfunction

    // idle burst length: none, or a random nonzero burst, with the given odds
    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) < pct)
            return $urandom_range(1, MAX_IDLE);
        return 0;
    endfunction

    // values lean toward a narrow band so duplicates are common
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VALUE_W'($signed($urandom_range(0, 16)) - 8);
            4:          return $urandom_range(0, 1) ? MAX_VALUE : MIN_VALUE;
            5:          return $urandom_range(0, 1) ? MAX_VALUE - 1 : MIN_VALUE + 1;
            default:    return $urandom;
        endcase
    endfunction

    task automatic push_item(logic op, logic signed [VALUE_W-1:0] value, int gap,
                             bit drain_first);
        queued_item_t q;
        q.item.operation = op;
        q.item.value_in  = value;
        q.gap            = gap;
        q.drain_first    = drain_first;
        pending_items.push_back(q);
    endtask

    // driver: presents queued items and records each accepted one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                awaited_results.push_back(predict_queue_op(in_data));
            if (!in_valid || in_ready)
            begin
                if (send_idle > 0)
                begin
                    send_idle--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() == 0)
                    in_valid <= 1'b0;
                else if (pending_items[0].drain_first && awaited_results.size() != 0)
                    // hold off until every outstanding result is back
                    in_valid <= 1'b0;
                else
                begin
                    in_data   <= pending_items[0].item;
                    in_valid  <= 1'b1;
                    send_idle  = pending_items[0].gap;
                    void'(pending_items.pop_front());
                end
            end
        end
    end

    // monitor: checks each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        out_item_t exp_r;
        int stall_pct;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: value_out=%0d status=%0d occupancy=%0d",
                                 out_data.value_out, out_data.status, out_data.occupancy);
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (out_data.value_out !== exp_r.value_out ||
                        out_data.status    !== exp_r.status ||
                        out_data.occupancy !== exp_r.occupancy)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("mismatch at result %0d: exp value_out=%0d status=%0d occupancy=%0d, got value_out=%0d status=%0d occupancy=%0d",
                                     results_seen, exp_r.value_out, exp_r.status,
                                     exp_r.occupancy, out_data.value_out,
                                     out_data.status, out_data.occupancy);
                    end
                end
            end

            // stall rate cycles through bands; no new stalls are picked in the tail of the run
            case ((results_seen / 200) % 4)
                0:       stall_pct = 0;
                1:       stall_pct = 5;
                2:       stall_pct = 20;
                default: stall_pct = 50;
            endcase
            if (pending_items.size() < QUIET_TAIL)
                stall_pct = 0;

            if (recv_idle > 0)
            begin
                recv_idle--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_idle  = pick_gap(stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int i;
        int left;
        int chunk;
        int enq_pct;
        int gap_pct;
        int issued;

        // directed: empty dequeue, duplicate of the only entry, extremes, full
        push_item(OP_DEQUEUE, MAX_VALUE, 0, 1'b0);
        push_item(OP_ENQUEUE, 32'sd5, 0, 1'b0);
        push_item(OP_ENQUEUE, 32'sd5, pick_gap(30), 1'b0);
        push_item(OP_ENQUEUE, MAX_VALUE, 0, 1'b0);
        push_item(OP_ENQUEUE, MIN_VALUE, pick_gap(30), 1'b0);
        push_item(OP_ENQUEUE, -32'sd1, 0, 1'b0);
        push_item(OP_ENQUEUE, 32'sd0, 0, 1'b0);
        for (i = 0; i < QUEUE_DEPTH - 6; i++)
            push_item(OP_ENQUEUE, pick_value(), pick_gap(30), 1'b0);
        // store is full here, so this one is dropped
        push_item(OP_ENQUEUE, MIN_VALUE, 0, 1'b0);
        push_item(OP_DEQUEUE, MIN_VALUE, 0, 1'b0);
        push_item(OP_ENQUEUE, MAX_VALUE, 0, 1'b0);
        push_item(OP_ENQUEUE, MAX_VALUE, 0, 1'b0);

        // random: chunks that lean toward filling, draining or a balance
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            chunk = $urandom_range(40, 150);
            case ($urandom_range(0, 3))
                0:       enq_pct = 80;
                1:       enq_pct = 20;
                2:       enq_pct = 50;
                default: enq_pct = 65;
            endcase
            case ($urandom_range(0, 3))
                0:       gap_pct = 0;
                1:       gap_pct = 5;
                2:       gap_pct = 25;
                default: gap_pct = 60;
            endcase
            for (i = 0; i < chunk && issued < RANDOM_ITEMS; i++)
            begin
                left = RANDOM_ITEMS - issued;
                push_item(($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                          pick_value(),
                          (left <= QUIET_TAIL) ? 0 : pick_gap(gap_pct),
                          (issued % 500) == 0);
                issued++;
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
